// ===== hdl/mspl_pkg.sv =====
// shared constants and codes for the motor speed pi loop core
package mspl_pkg;

  // channel count and the width of a channel index
  localparam int MOTOR_COUNT = 2;
  localparam int CH_W        = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // configuration register indexes
  localparam logic [2:0] REG_RPM_PER_COUNT  = 3'd0;
  localparam logic [2:0] REG_RAMP_STEP      = 3'd1;
  localparam logic [2:0] REG_SMOOTHING      = 3'd2;
  localparam logic [2:0] REG_KP_GAIN        = 3'd3;
  localparam logic [2:0] REG_KI_GAIN        = 3'd4;
  localparam logic [2:0] REG_TICK_SECONDS   = 3'd5;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;
  localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd7;

  // configuration reset values
  localparam logic [23:0] RST_RPM_PER_COUNT  = 24'd95906;
  localparam logic [30:0] RST_RAMP_STEP      = 31'd327680;
  localparam logic [16:0] RST_SMOOTHING      = 17'd32768;
  localparam logic [23:0] RST_KP_GAIN        = 24'd131072;
  localparam logic [23:0] RST_KI_GAIN        = 24'd4915200;
  localparam logic [15:0] RST_TICK_SECONDS   = 16'd6554;
  localparam logic [30:0] RST_INTEGRAL_LIMIT = 31'd124452864;
  localparam logic [14:0] RST_DRIVE_LIMIT    = 15'd4799;

  // unity filter weight in q1.16 and the near-zero setpoint band (0.1 rpm)
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic signed [31:0] NEAR_ZERO = 32'sd6554;

  // bridge direction codes
  localparam logic [1:0] DIR_STOP    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

endpackage

// ===== hdl/motor_speed_pi_loop_core.sv =====
// motor speed pi loop: speed measurement, ramped s-curve setpoint, pi drive
//
// Input channel (in_valid/in_stall) carries one control tick: motor index,
// raw encoder count and target speed (q15.16 rpm). A transfer happens when
// in_valid is high and in_stall is low. Output channel (out_valid/out_stall)
// returns measured speed, the smoothed setpoint, direction and pwm magnitude.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
// cfg_ready is always high. Write registers only while the core is idle.
// One tick runs from its input transfer through the sequencer to the result
// register and can then transfer out: a ten-step sequencer drives a
// single shared 34x25 multiplier, five products per tick, with the adders
// and clamps between them. A new tick is taken only once the sequencer is
// back in idle, so no tick is taken while another is in flight. The
// output register lets the next tick start while a result still waits; if
// it is still full when the next result is ready, the sequencer holds in its
// last step until out_stall drops.
// Synchronous reset loads the register defaults, clears all per-motor state
// (previous count, shadow ramp, smoothed ramp, error integral), empties
// the output register and holds in_stall high.
module motor_speed_pi_loop_core
  import mspl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               motor,
  input  logic signed [31:0] encoder_count,
  input  logic signed [31:0] target_rpm,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               motor_out,
  output logic signed [31:0] measured_rpm,
  output logic signed [31:0] ramped_setpoint,
  output logic [1:0]         direction,
  output logic [14:0]        drive_magnitude,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MEAS = 4'd1;
  localparam logic [3:0] S_FILT = 4'd2;
  localparam logic [3:0] S_SP   = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_STEP = 4'd5;
  localparam logic [3:0] S_INTG = 4'd6;
  localparam logic [3:0] S_ACC1 = 4'd7;
  localparam logic [3:0] S_ACC2 = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state;

  // configuration registers
  logic [23:0] rpm_per_count;
  logic [30:0] ramp_step;
  logic [16:0] smoothing;
  logic [23:0] kp_gain;
  logic [23:0] ki_gain;
  logic [15:0] tick_seconds;
  logic [30:0] integral_limit;
  logic [14:0] drive_limit;

  // per-motor state
  logic signed [31:0] prev_count  [MOTOR_COUNT];
  logic signed [31:0] shadow_ramp [MOTOR_COUNT];
  logic signed [31:0] smooth_ramp [MOTOR_COUNT];
  logic signed [31:0] err_integ   [MOTOR_COUNT];

  // working registers for the tick in flight
  logic [CH_W-1:0]    ch;
  logic               motor_r;
  logic signed [31:0] count_r;
  logic signed [31:0] target_r;
  logic signed [31:0] delta;
  logic signed [31:0] shadow_cur;
  logic signed [31:0] smooth_cur;
  logic signed [31:0] integ_cur;
  logic signed [31:0] shadow_new;
  logic signed [31:0] meas;
  logic signed [31:0] sp;
  logic signed [32:0] err;
  logic signed [31:0] integ_new;
  logic signed [58:0] acc;

  // shared multiplier and its product register
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] prod;

  logic [CH_W-1:0]    ch_in;
  logic signed [31:0] shadow_next;
  logic signed [31:0] meas_next;
  logic signed [31:0] sp_next;
  logic signed [32:0] err_next;
  logic signed [31:0] integ_next;
  logic [1:0]         dir_next;
  logic [14:0]        mag_next;
  logic               done_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || (state != S_IDLE);
  assign ch_in     = CH_W'(32'(motor) % MOTOR_COUNT);
  assign done_load = (state == S_DONE) && (!out_valid || !out_stall);

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_per_count  <= RST_RPM_PER_COUNT;
      ramp_step      <= RST_RAMP_STEP;
      smoothing      <= RST_SMOOTHING;
      kp_gain        <= RST_KP_GAIN;
      ki_gain        <= RST_KI_GAIN;
      tick_seconds   <= RST_TICK_SECONDS;
      integral_limit <= RST_INTEGRAL_LIMIT;
      drive_limit    <= RST_DRIVE_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RPM_PER_COUNT:  rpm_per_count  <= cfg_data[23:0];
        REG_RAMP_STEP:      ramp_step      <= cfg_data[30:0];
        REG_SMOOTHING:      smoothing      <= cfg_data[16:0];
        REG_KP_GAIN:        kp_gain        <= cfg_data[23:0];
        REG_KI_GAIN:        ki_gain        <= cfg_data[23:0];
        REG_TICK_SECONDS:   tick_seconds   <= cfg_data[15:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[30:0];
        REG_DRIVE_LIMIT:    drive_limit    <= cfg_data[14:0];
        default:            drive_limit    <= drive_limit;
      endcase
    end
  end

  // multiplier operand select per step
  always_comb begin
    logic [16:0]        w;
    logic signed [32:0] diff;
    w    = (smoothing > WEIGHT_ONE) ? WEIGHT_ONE : smoothing;
    diff = 33'(shadow_new) - 33'(smooth_cur);
    case (state)
      S_MEAS: begin
        mul_a = 34'(delta);
        mul_b = {1'b0, rpm_per_count};
      end
      S_FILT: begin
        mul_a = 34'(diff);
        mul_b = {8'b0, w};
      end
      S_STEP: begin
        mul_a = 34'(err);
        mul_b = {9'b0, tick_seconds};
      end
      S_INTG: begin
        mul_a = 34'(err);
        mul_b = {1'b0, kp_gain};
      end
      S_ACC1: begin
        mul_a = 34'(integ_new);
        mul_b = {1'b0, ki_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // linear shadow ramp toward the target, limited by ramp_step
  always_comb begin
    logic signed [33:0] up;
    logic signed [33:0] dn;
    logic signed [33:0] tgt;
    tgt = 34'(target_r);
    up  = 34'(shadow_cur) + $signed({3'b0, ramp_step});
    dn  = 34'(shadow_cur) - $signed({3'b0, ramp_step});
    if (shadow_cur < target_r) begin
      shadow_next = (up > tgt) ? target_r : up[31:0];
    end else if (shadow_cur > target_r) begin
      shadow_next = (dn < tgt) ? target_r : dn[31:0];
    end else begin
      shadow_next = shadow_cur;
    end
  end

  // measured speed saturated to 32 bits
  always_comb begin
    if (prod[58:31] == {28{prod[58]}}) begin
      meas_next = prod[31:0];
    end else if (prod[58]) begin
      meas_next = 32'sh80000000;
    end else begin
      meas_next = 32'sh7FFFFFFF;
    end
  end

  // filter output: floor of the weighted step added to the old value
  always_comb begin
    logic signed [33:0] sum;
    sum     = 34'(smooth_cur) + prod[49:16];
    sp_next = sum[31:0];
  end

  assign err_next = 33'(sp) - 33'(meas);

  // integral: clear on sign conflict or near-zero setpoint, then clamp
  always_comb begin
    logic signed [34:0] sum;
    logic signed [34:0] lim;
    logic               clr;
    lim = $signed({4'b0, integral_limit});
    clr = (!sp[31] && integ_cur < 0) || ((sp[31] || sp == 0) && integ_cur > 0) ||
          (sp > -NEAR_ZERO && sp < NEAR_ZERO);
    sum = clr ? 35'sd0 : (35'(integ_cur) + 35'($signed(prod[49:16])));
    if (sum > lim) begin
      integ_next = lim[31:0];
    end else if (sum < -lim) begin
      integ_next = 32'(-lim);
    end else begin
      integ_next = sum[31:0];
    end
  end

  // drive: magnitude truncated toward zero, clamped, split into direction
  always_comb begin
    logic [58:0] mag_abs;
    logic [26:0] mag_full;
    mag_abs  = acc[58] ? 59'(-acc) : 59'(acc);
    mag_full = mag_abs[58:32];
    mag_next = (mag_full > 27'(drive_limit)) ? drive_limit : mag_full[14:0];
    if (mag_next == '0) begin
      dir_next = DIR_STOP;
    end else if (acc[58]) begin
      dir_next = DIR_REVERSE;
    end else begin
      dir_next = DIR_FORWARD;
    end
  end

  // shared product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_MEAS;
        S_MEAS:  state <= S_FILT;
        S_FILT:  state <= S_SP;
        S_SP:    state <= S_ERR;
        S_ERR:   state <= S_STEP;
        S_STEP:  state <= S_INTG;
        S_INTG:  state <= S_ACC1;
        S_ACC1:  state <= S_ACC2;
        S_ACC2:  state <= S_DONE;
        S_DONE:  if (done_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers for the tick in flight
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ch         <= ch_in;
        motor_r    <= motor;
        count_r    <= encoder_count;
        target_r   <= target_rpm;
        delta      <= encoder_count - prev_count[ch_in];
        shadow_cur <= shadow_ramp[ch_in];
        smooth_cur <= smooth_ramp[ch_in];
        integ_cur  <= err_integ[ch_in];
      end
      S_MEAS: shadow_new <= shadow_next;
      S_FILT: meas       <= meas_next;
      S_SP:   sp         <= sp_next;
      S_ERR:  err        <= err_next;
      S_INTG: integ_new  <= integ_next;
      S_ACC1: acc        <= prod;
      S_ACC2: acc        <= acc + prod;
      default: acc       <= acc;
    endcase
  end

  // per-motor state update when the result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        prev_count[i]  <= '0;
        shadow_ramp[i] <= '0;
        smooth_ramp[i] <= '0;
        err_integ[i]   <= '0;
      end
    end else if (done_load) begin
      prev_count[ch]  <= count_r;
      shadow_ramp[ch] <= shadow_new;
      smooth_ramp[ch] <= sp;
      err_integ[ch]   <= integ_new;
    end
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (done_load) begin
      motor_out       <= motor_r;
      measured_rpm    <= meas;
      ramped_setpoint <= sp;
      direction       <= dir_next;
      drive_magnitude <= mag_next;
    end
  end

endmodule

// ===== hdl/mspl_checker.sv =====
// port-level checks for the motor speed pi loop core, bound to the top level
module mspl_checker
  import mspl_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               motor_out,
  input logic signed [31:0] measured_rpm,
  input logic signed [31:0] ramped_setpoint,
  input logic [1:0]         direction,
  input logic [14:0]        drive_magnitude
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(measured_rpm) &&
      $stable(ramped_setpoint) && $stable(direction) &&
      $stable(drive_magnitude) && $stable(motor_out)))
    else $error("stalled result changed");

  // the sequencer is busy in the cycle after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a tick is in flight");

  // stop exactly when the magnitude is zero
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((direction == DIR_STOP) == (drive_magnitude == 15'd0)))
    else $error("direction and magnitude disagree");

endmodule

bind motor_speed_pi_loop_core mspl_checker u_mspl_checker (.*);
